// ----- design/mwpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mwpq_pkg
// Shared types and codes for the minimum-weight priority queue.
// ----------------------------------------------------------------------------
package mwpq_pkg;

	localparam int SYM_W    = 8;
	localparam int OCC_W    = 9;
	localparam int STATUS_W = 2;

	// Operation codes on func
	localparam logic FN_ENQ = 1'b0;
	localparam logic FN_DEQ = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_SHIFT
	} state_t;

	// Sequencer controls for the datapath
	typedef struct packed {
		logic enq_wr;    // append at tail
		logic enq_full;  // enqueue refused
		logic deq_empty; // dequeue refused
		logic deq_go;    // dequeue accepted, scan begins
		logic scan_rd;   // issue scan read
		logic drain;     // last compare lands
		logic shift_rd;  // issue shift read
		logic finish;    // dequeue result
	} ctl_t;

endpackage

// ----- design/min_weight_priority_queue.sv -----
// ----------------------------------------------------------------------------
// min_weight_priority_queue
// Insertion-ordered list of (symbol, weight) pairs; dequeue removes the
// lightest entry, earliest first on equal weights, and closes the gap.
// ----------------------------------------------------------------------------
//  channel  | handshake               | fields
//  ---------+-------------------------+-------------------------------------
//  command  | start (in), busy (out)  | func, symbol, weight
//  result   | done strobe, one cycle  | status, out_symbol, out_weight,
//           |                         | occupancy
//
// Enqueue and refused items: result in the cycle after the transfer, busy stays
// low, so items may follow every cycle.
// Dequeue of n entries: the scan reads all n entries, a drain state lands the
// last compare, and the shift state closes the gap; busy holds off the next
// transfer until the result. Scan and gap shift share the single read port.
// Reset leaves the queue empty; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module min_weight_priority_queue
	import mwpq_pkg::*;
#(
	parameter int DEPTH       = 256,
	parameter int WEIGHT_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   func,
	input  logic [SYM_W-1:0]       symbol,
	input  logic [WEIGHT_BITS-1:0] weight,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [SYM_W-1:0]       out_symbol,
	output logic [WEIGHT_BITS-1:0] out_weight,
	output logic [OCC_W-1:0]       occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = SYM_W + WEIGHT_BITS;

	state_t state_q, state_nx;
	ctl_t   ctl;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_s1;
	logic          scan_s1;
	logic          shift_s1;
	logic [CW-1:0] best_idx_q;
	logic [CW-1:0] best_nx;
	logic [SYM_W-1:0]       best_sym_q;
	logic [WEIGHT_BITS-1:0] best_w_q;
	logic          cmp_take;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;
	logic [SYM_W-1:0]       rd_sym;
	logic [WEIGHT_BITS-1:0] rd_w;

	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [SYM_W-1:0]       out_symbol_q;
	logic [WEIGHT_BITS-1:0] out_weight_q;
	logic [CW+OCC_W-1:0]    occ_ext;

	logic accept;
	logic full;

	assign accept  = start && !busy;
	assign full    = (count_q == CW'(DEPTH));
	assign idx_inc = idx_q + 1'b1;

	// ---------------- sequencer ----------------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && func == FN_DEQ && count_q != '0) begin
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				if (idx_inc == count_q) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: state_nx = S_SHIFT;
			S_SHIFT: begin
				if (idx_inc >= count_q) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FN_ENQ) begin
						ctl.enq_wr   = !full;
						ctl.enq_full = full;
					end else begin
						ctl.deq_go    = (count_q != '0);
						ctl.deq_empty = (count_q == '0);
					end
				end
			end
			S_SCAN:  ctl.scan_rd = 1'b1;
			S_DRAIN: ctl.drain   = 1'b1;
			S_SHIFT: begin
				ctl.shift_rd = (idx_inc < count_q);
				ctl.finish   = (idx_inc >= count_q);
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

	// ---------------- entry store ----------------
	assign mem_we    = ctl.enq_wr || shift_s1;
	assign mem_waddr = shift_s1 ? idx_s1[AW-1:0] : count_q[AW-1:0];
	assign mem_wdata = shift_s1 ? mem_rdata : {symbol, weight};
	assign mem_raddr = ctl.shift_rd ? idx_inc[AW-1:0] : idx_q[AW-1:0];

	mwpq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_sym = mem_rdata[DW-1 -: SYM_W];
	assign rd_w   = mem_rdata[WEIGHT_BITS-1:0];

	// scan comparator: strict less-than keeps the earliest on ties
	assign cmp_take = scan_s1 && ((idx_s1 == '0) || (rd_w < best_w_q));
	assign best_nx  = cmp_take ? idx_s1 : best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1  <= 1'b0;
			shift_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			scan_s1  <= ctl.scan_rd;
			shift_s1 <= ctl.shift_rd;
			if (ctl.enq_wr) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.finish) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ctl.shift_rd ? idx_q : idx_q;
		if (ctl.deq_go) begin
			idx_q <= '0;
		end else if (ctl.scan_rd || ctl.shift_rd) begin
			idx_q <= idx_inc;
		end else if (ctl.drain) begin
			idx_q <= best_nx;
		end
		if (cmp_take) begin
			best_idx_q <= idx_s1;
			best_sym_q <= rd_sym;
			best_w_q   <= rd_w;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.enq_wr || ctl.enq_full || ctl.deq_empty || ctl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status_q     <= ST_DONE;
			out_symbol_q <= best_sym_q;
			out_weight_q <= best_w_q;
		end else if (ctl.enq_wr || ctl.enq_full || ctl.deq_empty) begin
			priority if (ctl.enq_full) begin
				status_q <= ST_FULL;
			end else if (ctl.deq_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
			end
			out_symbol_q <= '0;
			out_weight_q <= '0;
		end
	end

	assign occ_ext    = {{OCC_W{1'b0}}, count_q};
	assign done       = done_q;
	assign status     = status_q;
	assign out_symbol = out_symbol_q;
	assign out_weight = out_weight_q;
	assign occupancy  = occ_ext[OCC_W-1:0];

endmodule

// ----- design/mwpq_mem.sv -----
// ----------------------------------------------------------------------------
// mwpq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mwpq_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- design/mwpq_chk.sv -----
// ----------------------------------------------------------------------------
// mwpq_chk
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mwpq_chk
	import mwpq_pkg::*;
#(
	parameter int DEPTH       = 256,
	parameter int WEIGHT_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   func,
	input logic                   done,
	input logic [STATUS_W-1:0]    status,
	input logic [SYM_W-1:0]       out_symbol,
	input logic [WEIGHT_BITS-1:0] out_weight,
	input logic [OCC_W-1:0]       occupancy
);

	// a result always lands with the sequencer back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an enqueue transfer is answered in the next cycle
	a_enq_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_ENQ) |=> done)
		else $error("enqueue not answered next cycle");

	// a dequeue transfer either starts the scan or is refused at once
	a_deq_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_DEQ) |=> (busy || (done && status == ST_EMPTY)))
		else $error("dequeue neither scanned nor refused");

	// refused items carry a zero pair (successful enqueues, status ST_DONE, are not checked)
	a_zero_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (out_symbol == '0 && out_weight == '0))
		else $error("non-zero pair on refused item");

	// full refusal only with the store at capacity
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)))
		else $error("full status below capacity");

endmodule

bind min_weight_priority_queue mwpq_chk #(
	.DEPTH       (DEPTH),
	.WEIGHT_BITS (WEIGHT_BITS)
) u_mwpq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.func       (func),
	.done       (done),
	.status     (status),
	.out_symbol (out_symbol),
	.out_weight (out_weight),
	.occupancy  (occupancy)
);
